>>> design/bblc_pkg.sv
// Shared types and constants for the byte-budget LRU tag store.
// Used by the cell, the controller and the top level; no dependencies.
package bblc_pkg;

  localparam int KEY_W       = 25;
  localparam int SIZE_W      = 19;
  localparam int TOTAL_W     = 29;
  localparam int BUDGET_W    = 28;
  localparam int NOTICE_W    = 6;
  localparam int DEF_ENTRIES = 64;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(48 * 1024 * 1024);
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = {TOTAL_W{1'b1}};
  // at most this many eviction notices per request, the answer takes the last slot
  localparam logic [NOTICE_W-1:0] MAX_NOTICES  = {NOTICE_W{1'b1}};

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;
  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_COMPARE,
    OP_PROMOTE,
    OP_SHIFT,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [KEY_W-1:0]    key;
    logic [SIZE_W-1:0]   size;
  } cell_cmd_t;

  // chain status seen by the controller
  typedef struct packed {
    logic                hit_any;
    logic                multi;
    logic                full;
    logic [KEY_W-1:0]    lru_key;
    logic [SIZE_W-1:0]   lru_size;
  } chain_stat_t;

endpackage

>>> design/byte_budget_lru_cache.sv
// Byte-budget LRU tag store: a chain of ENTRIES cells ordered by recency with
// the least recent entry in cell 0, driven by the request sequencer. One request
// is worked at a time. On a miss the chain sheds entries at its least recent end
// as the budget demands, shifting by one cell per cycle while out_stall does not
// hold the result register; making room in a full table shares its cycle with
// the lookup decision. Every step that loads the result register waits while
// out_stall holds it. Depends on bblc_pkg, bblc_cell and bblc_ctrl.
module byte_budget_lru_cache import bblc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [15:0]         species_id,
  input  logic [7:0]          form_id,
  input  logic                shiny,
  input  logic [SIZE_W-1:0]   item_bytes,
  input  logic                cfg_wr_en,
  input  logic [BUDGET_W-1:0] cfg_wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic                hit,
  output logic [KEY_W-1:0]    evicted_key,
  output logic [SIZE_W-1:0]   freed_bytes,
  output logic [TOTAL_W-1:0]  total_bytes,
  output logic                last
);

  cell_cmd_t         cmd;
  chain_stat_t       stat;
  logic              busy;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES:0]   ge_chain;
  logic [KEY_W-1:0]   key_arr  [ENTRIES];
  logic [SIZE_W-1:0]  size_arr [ENTRIES];
  logic [SIZE_W-1:0]  hsize_arr[ENTRIES];
  logic [SIZE_W-1:0]  promo_size;

  assign in_stall    = busy;
  assign ge_chain[0] = 1'b0;

  // recency chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]  up_key;
    logic [SIZE_W-1:0] up_size;
    logic              up_valid;
    logic              dn_valid;

    if (i == ENTRIES - 1) begin : g_top
      assign up_key   = '0;
      assign up_size  = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid
      assign up_key   = key_arr[i+1];
      assign up_size  = size_arr[i+1];
      assign up_valid = valid_vec[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_valid = 1'b1;
    end else begin : g_up
      assign dn_valid = valid_vec[i-1];
    end

    bblc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .promo_size (promo_size),
      .up_key     (up_key),
      .up_size    (up_size),
      .up_valid   (up_valid),
      .dn_valid   (dn_valid),
      .ge_in      (ge_chain[i]),
      .valid      (valid_vec[i]),
      .key        (key_arr[i]),
      .size       (size_arr[i]),
      .ge_out     (ge_chain[i+1]),
      .hit        (hit_vec[i]),
      .hit_size   (hsize_arr[i])
    );
  end

  // size of the hit entry, at most one cell contributes
  always_comb begin
    promo_size = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      promo_size = promo_size | hsize_arr[i];
    end
  end

  assign stat = '{hit_any:  |hit_vec,
                  multi:    valid_vec[1],
                  full:     valid_vec[ENTRIES-1],
                  lru_key:  key_arr[0],
                  lru_size: size_arr[0]};

  bblc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .action      (action),
    .species_id  (species_id),
    .form_id     (form_id),
    .shiny       (shiny),
    .item_bytes  (item_bytes),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .kind        (kind),
    .hit         (hit),
    .evicted_key (evicted_key),
    .freed_bytes (freed_bytes),
    .total_bytes (total_bytes),
    .last        (last)
  );

  // occupied cells stay packed at the lru end
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("cell chain has a hole");

  // a notice always reports freed bytes
  a_notice_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NOTICE) |-> (freed_bytes != '0))
    else $error("notice with zero freed bytes");

  // no new word taken before the answer of the current one is out
  a_busy_notice: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> in_stall)
    else $error("input taken while notices still pending");

endmodule

>>> design/bblc_cell.sv
// One entry of the recency chain: key, size, valid and the hit flags.
// Cell 0 holds the least recent entry; depends on bblc_pkg.
module bblc_cell import bblc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic [SIZE_W-1:0] promo_size,
  input  logic [KEY_W-1:0]  up_key,
  input  logic [SIZE_W-1:0] up_size,
  input  logic              up_valid,
  input  logic              dn_valid,
  input  logic              ge_in,
  output logic              valid,
  output logic [KEY_W-1:0]  key,
  output logic [SIZE_W-1:0] size,
  output logic              ge_out,
  output logic              hit,
  output logic [SIZE_W-1:0] hit_size
);

  logic match;
  logic ge;
  logic tail;

  // key compare and at-or-above-hit flag rippled from the lru end
  assign match    = valid && (key == cmd.key);
  assign ge_out   = match || ge_in;
  assign tail     = valid && !up_valid;
  assign hit_size = hit ? size : '0;

  // cell state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
      ge    <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_HOLD: ;
        OP_CLEAR: valid <= 1'b0;
        OP_COMPARE: begin
          hit <= match;
          ge  <= ge_out;
        end
        OP_PROMOTE: begin
          // hit entry goes to the most recent slot, the ones above it slide down
          if (tail) begin
            key  <= cmd.key;
            size <= promo_size;
          end else if (ge && valid) begin
            key  <= up_key;
            size <= up_size;
          end
        end
        OP_SHIFT: begin
          valid <= up_valid;
          key   <= up_key;
          size  <= up_size;
        end
        OP_INSERT: begin
          if (!valid && dn_valid) begin
            valid <= 1'b1;
            key   <= cmd.key;
            size  <= cmd.size;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/bblc_ctrl.sv
// Request sequencer: byte total, budget register, notice count and result word.
// Drives the cell chain through cell_cmd_t; depends on bblc_pkg.
module bblc_ctrl import bblc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                action,
  input  logic [15:0]         species_id,
  input  logic [7:0]          form_id,
  input  logic                shiny,
  input  logic [SIZE_W-1:0]   item_bytes,
  input  logic                cfg_wr_en,
  input  logic [BUDGET_W-1:0] cfg_wr_data,
  input  logic                out_stall,
  input  chain_stat_t         stat,
  output logic                busy,
  output cell_cmd_t           cmd,
  output logic                out_valid,
  output logic                kind,
  output logic                hit,
  output logic [KEY_W-1:0]    evicted_key,
  output logic [SIZE_W-1:0]   freed_bytes,
  output logic [TOTAL_W-1:0]  total_bytes,
  output logic                last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DEC,
    ST_INS,
    ST_TRIM
  } state_t;

  state_t              state;
  logic                req_flush;
  logic [KEY_W-1:0]    req_key;
  logic [SIZE_W-1:0]   req_size;
  logic [TOTAL_W-1:0]  total;
  logic [BUDGET_W-1:0] budget;
  logic [NOTICE_W-1:0] notices;

  logic                out_free;
  logic                out_load;
  logic                trim_go;
  logic [TOTAL_W-1:0]  lru_size_ext;
  logic [TOTAL_W-1:0]  sub_total;
  logic [TOTAL_W:0]    add_sum;
  logic [TOTAL_W-1:0]  add_total;
  cell_op_t            op;

  assign busy     = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // total arithmetic: floor at zero on eviction, saturate on insert
  assign lru_size_ext = {{(TOTAL_W-SIZE_W){1'b0}}, stat.lru_size};
  assign sub_total    = (total >= lru_size_ext) ? (total - lru_size_ext) : '0;
  assign add_sum      = {1'b0, total} + {{(TOTAL_W+1-SIZE_W){1'b0}}, req_size};
  assign add_total    = add_sum[TOTAL_W] ? TOTAL_MAX : add_sum[TOTAL_W-1:0];
  assign trim_go      = (total > {1'b0, budget}) && stat.multi && (notices != MAX_NOTICES);

  // chain command for this cycle and whether a result word is loaded
  always_comb begin
    op       = OP_HOLD;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_LOOK: begin
        if (req_flush == ACT_FLUSH) begin
          if (out_free) begin
            op       = OP_CLEAR;
            out_load = 1'b1;
          end
        end else begin
          op = OP_COMPARE;
        end
      end
      ST_DEC: begin
        if (out_free && stat.hit_any) begin
          op       = OP_PROMOTE;
          out_load = 1'b1;
        end else if (out_free && stat.full) begin
          op       = OP_SHIFT;
          out_load = (stat.lru_size != '0);
        end
      end
      ST_INS: op = OP_INSERT;
      ST_TRIM: begin
        if (out_free) begin
          if (trim_go) begin
            op       = OP_SHIFT;
            out_load = (stat.lru_size != '0);
          end else begin
            out_load = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign cmd = '{op: op, key: req_key, size: req_size};

  // state, totals and the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      budget    <= BUDGET_RESET;
      notices   <= '0;
    end else begin
      if (cfg_wr_en) budget <= cfg_wr_data;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_flush <= action;
            req_key   <= {species_id, form_id, shiny};
            req_size  <= item_bytes;
            notices   <= '0;
            state     <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (req_flush == ACT_FLUSH) begin
            if (out_free) begin
              total       <= '0;
              kind        <= KIND_ANSWER;
              hit         <= 1'b0;
              evicted_key <= '0;
              freed_bytes <= '0;
              total_bytes <= '0;
              last        <= 1'b1;
              state       <= ST_IDLE;
            end
          end else begin
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (stat.hit_any) begin
            if (out_free) begin
              kind        <= KIND_ANSWER;
              hit         <= 1'b1;
              evicted_key <= '0;
              freed_bytes <= '0;
              total_bytes <= total;
              last        <= 1'b1;
              state       <= ST_IDLE;
            end
          end else if (stat.full) begin
            // full table: the least recent entry makes room first
            if (out_free) begin
              total <= sub_total;
              if (stat.lru_size != '0) begin
                kind        <= KIND_NOTICE;
                hit         <= 1'b0;
                evicted_key <= stat.lru_key;
                freed_bytes <= stat.lru_size;
                total_bytes <= sub_total;
                last        <= 1'b0;
                notices     <= notices + 1'b1;
              end
              state <= ST_INS;
            end
          end else begin
            state <= ST_INS;
          end
        end
        ST_INS: begin
          total <= add_total;
          state <= ST_TRIM;
        end
        ST_TRIM: begin
          if (trim_go) begin
            if (out_free) begin
              total <= sub_total;
              if (stat.lru_size != '0) begin
                kind        <= KIND_NOTICE;
                hit         <= 1'b0;
                evicted_key <= stat.lru_key;
                freed_bytes <= stat.lru_size;
                total_bytes <= sub_total;
                last        <= 1'b0;
                notices     <= notices + 1'b1;
              end
            end
          end else if (out_free) begin
            kind        <= KIND_ANSWER;
            hit         <= 1'b0;
            evicted_key <= '0;
            freed_bytes <= '0;
            total_bytes <= total;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
